// ----- rtl/erdl_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Encoder step accumulator package
// Shared constants, direction codes, register index codes and the divider request/response types.
// ----------------------------------------------------------------------------
package erdl_pkg;

  localparam int NUM_SENSORS = 4;
  localparam int NUM_LAYERS  = 8;

  localparam int STORE_DEPTH = NUM_SENSORS * NUM_LAYERS;
  localparam int STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int SENS_W      = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;

  // remainder store entry: {degrees, micro degrees}, both signed
  localparam int REM_DEG_W = 10;
  localparam int REM_MIC_W = 21;
  localparam int REM_W     = REM_DEG_W + REM_MIC_W;

  localparam int MICRO_PER_DEGREE = 1000000;
  localparam int DEGREES_PER_TURN = 360;
  localparam int TAP_MAX          = 65535;

  localparam int SPR_W  = 9;
  localparam int HOLD_W = 16;

  // shared restoring divider
  localparam int DIV_DVD_W = 16;
  localparam int DIV_DVS_W = 9;
  localparam int DIV_CNT_W = $clog2(DIV_DVD_W + 1);

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_CW   = 2'd1,
    DIR_CCW  = 2'd2
  } dir_t;

  typedef enum logic [0:0] {
    CFG_STEPS_PER_ROT = 1'b0,
    CFG_HOLD_TIME     = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_CNT_W-1:0] iters;
    logic [DIV_DVD_W-1:0] dividend;
    logic [DIV_DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic [DIV_DVD_W-1:0] quotient;
    logic [DIV_DVS_W-1:0] remainder;
  } div_rsp_t;

endpackage
`default_nettype wire

// ----- rtl/erdl_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module erdl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                        clk,
  input  wire logic                                        we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                            wdata,
  input  wire logic                                        re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/erdl_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Shared restoring divider
// Unsigned, one quotient bit per cycle, MSB first, for a chosen bit count.
// ----------------------------------------------------------------------------
module erdl_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire erdl_pkg::div_req_t req,
  output erdl_pkg::div_rsp_t      rsp
);

  logic                           busy_r, busy_nxt;
  logic [erdl_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [erdl_pkg::DIV_DVD_W-1:0] quo_r, quo_nxt;
  logic [erdl_pkg::DIV_DVS_W-1:0] rem_r, rem_nxt;
  logic [erdl_pkg::DIV_DVS_W-1:0] dvs_r, dvs_nxt;
  logic [erdl_pkg::DIV_DVS_W:0]   trial;
  logic [erdl_pkg::DIV_DVS_W:0]   diff;
  logic                           qbit;

  always_comb begin
    trial = {rem_r, quo_r[erdl_pkg::DIV_DVD_W-1]};
    diff  = trial - {1'b0, dvs_r};
    qbit  = (trial >= {1'b0, dvs_r});

    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;

    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = req.iters;
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      // remainder stays below divisor, so the difference fits back
      rem_nxt = qbit ? diff[erdl_pkg::DIV_DVS_W-1:0] : trial[erdl_pkg::DIV_DVS_W-1:0];
      quo_nxt = {quo_r[erdl_pkg::DIV_DVD_W-2:0], qbit};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == erdl_pkg::DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.busy      = busy_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule
`default_nettype wire

// ----- rtl/encoder_rotation_direction_lock.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Rotary encoder step accumulator with reversal lockout
// Turns rotation reports into a direction and a saturated tap count.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one rotation report per item (sensor, layer, degrees, micro, ms).
//   out_* : one result per report (direction, tap count, dropped flag).
//   cfg_* : register writes, always ready; write only while the block is idle.
// Flow:
//   Raw step reports and reports with an index out of range go from the
//   accepting edge straight to the result state, which raises out_tvalid.
//   Angle reports run 9 divider iterations for the step size (overlapping
//   the carry and sum states), start the second divide, run 16 iterations
//   for the step count, write back the remainder and then raise the result.
//   One report is in flight at a time and in_tready returns with out_tvalid.
// Reset:
//   After rst_n the remainder RAM's 32 entries are swept to zero, one entry
//   per cycle; in_tready stays low meanwhile. Registers return to 20
//   steps per turn and a 100 ms hold time.
// Stall:
//   The result sits in an output register; the next report is accepted
//   while it waits, but its result is held back until out_tready.
// ----------------------------------------------------------------------------
module encoder_rotation_direction_lock (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in_tdata: sensor_id[1:0], layer_index[4:2], whole_degrees[20:5],
  //           micro_degrees[41:21], now_ms[73:42], zero pad[79:74]
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [79:0] in_tdata,
  // out_tdata: direction[1:0], tap_count[17:2], reversal_dropped[18],
  //            zero pad[23:19]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [23:0] out_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CARRY,
    S_SUM,
    S_DIV1,
    S_DIV2,
    S_LOCK
  } state_t;

  localparam logic signed [21:0] MIC_ONE     = 22'(erdl_pkg::MICRO_PER_DEGREE);
  localparam logic signed [21:0] MIC_TWO     = 22'(2 * erdl_pkg::MICRO_PER_DEGREE);
  localparam logic signed [21:0] MIC_NEG_ONE = -MIC_ONE;
  localparam logic signed [21:0] MIC_NEG_TWO = -MIC_TWO;

  // input fields
  logic [1:0]  in_sensor;
  logic [2:0]  in_layer;
  logic [15:0] in_whole;
  logic [20:0] in_micro;
  logic [31:0] in_now;

  assign in_sensor = in_tdata[1:0];
  assign in_layer  = in_tdata[4:2];
  assign in_whole  = in_tdata[20:5];
  assign in_micro  = in_tdata[41:21];
  assign in_now    = in_tdata[73:42];

  state_t state_r, state_nxt;

  logic [erdl_pkg::SPR_W-1:0]  spr_r, spr_nxt;
  logic [erdl_pkg::HOLD_W-1:0] hold_r, hold_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [1:0]                    out_dir_r, out_dir_nxt;
  logic [15:0]                   out_tap_r, out_tap_nxt;
  logic                          out_drop_r, out_drop_nxt;

  erdl_pkg::dir_t last_dir_r  [erdl_pkg::NUM_SENSORS];
  erdl_pkg::dir_t last_dir_nxt[erdl_pkg::NUM_SENSORS];
  logic [31:0]    last_time_r  [erdl_pkg::NUM_SENSORS];
  logic [31:0]    last_time_nxt[erdl_pkg::NUM_SENSORS];

  logic [erdl_pkg::STORE_AW-1:0] clr_cnt_r, clr_cnt_nxt;

  // per-item payload
  logic [1:0]                    sensor_r, sensor_nxt;
  logic [erdl_pkg::STORE_AW-1:0] addr_r, addr_nxt;
  logic [15:0]                   whole_r, whole_nxt;
  logic [20:0]                   micro_r, micro_nxt;
  logic [31:0]                   now_r, now_nxt;
  logic [20:0]                   mic_new_r, mic_new_nxt;
  logic [2:0]                    carry_r, carry_nxt;
  logic                          deg_neg_r, deg_neg_nxt;
  logic [15:0]                   deg_abs_r, deg_abs_nxt;
  logic [20:0]                   steps_mag_r, steps_mag_nxt;
  logic                          steps_neg_r, steps_neg_nxt;

  // remainder RAM
  logic                          ram_we, ram_re;
  logic [erdl_pkg::STORE_AW-1:0] ram_waddr, ram_raddr;
  logic [erdl_pkg::REM_W-1:0]    ram_wdata, ram_rdata;
  logic [9:0]                    rd_deg;
  logic [20:0]                   rd_mic;

  erdl_pkg::div_req_t div_req;
  erdl_pkg::div_rsp_t div_rsp;

  // working values
  logic                          accept;
  logic                          idx_ok;
  logic [erdl_pkg::SPR_W-1:0]    spr_eff;
  logic signed [21:0]            mic_sum;
  logic [17:0]                   deg_sum;
  logic [17:0]                   deg_mag;
  logic [9:0]                    rem_deg;
  logic [erdl_pkg::SENS_W-1:0]   sidx;
  logic                          nonzero;
  erdl_pkg::dir_t                step_dir;
  erdl_pkg::dir_t                prev_dir;
  logic [31:0]                   elapsed;
  logic                          drop;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  assign idx_ok = (32'(in_sensor) < erdl_pkg::NUM_SENSORS)
               && (32'(in_layer) < erdl_pkg::NUM_LAYERS);

  assign rd_deg = ram_rdata[erdl_pkg::REM_W-1:erdl_pkg::REM_MIC_W];
  assign rd_mic = ram_rdata[erdl_pkg::REM_MIC_W-1:0];

  always_comb begin
    if (spr_r == '0) begin
      spr_eff = erdl_pkg::SPR_W'(1);
    end else if (spr_r > erdl_pkg::SPR_W'(erdl_pkg::DEGREES_PER_TURN)) begin
      spr_eff = erdl_pkg::SPR_W'(erdl_pkg::DEGREES_PER_TURN);
    end else begin
      spr_eff = spr_r;
    end
  end

  // micro carry: the sum of two signed 21-bit values fits 22 bits
  assign mic_sum = $signed({rd_mic[20], rd_mic}) + $signed({micro_r[20], micro_r});

  assign deg_sum = {{8{rd_deg[9]}}, rd_deg} + {{2{whole_r[15]}}, whole_r}
                 + {{15{carry_r[2]}}, carry_r};
  assign deg_mag = deg_sum[17] ? (18'd0 - deg_sum) : deg_sum;

  assign rem_deg = deg_neg_r ? (10'd0 - {1'b0, div_rsp.remainder})
                             : {1'b0, div_rsp.remainder};

  assign sidx     = erdl_pkg::SENS_W'(sensor_r);
  assign nonzero  = (steps_mag_r != '0);
  assign step_dir = steps_neg_r ? erdl_pkg::DIR_CCW : erdl_pkg::DIR_CW;
  assign prev_dir = last_dir_r[sidx];
  assign elapsed  = now_r - last_time_r[sidx];
  assign drop     = (prev_dir != erdl_pkg::DIR_NONE) && (step_dir != prev_dir)
                 && (elapsed < {16'd0, hold_r});

  always_comb begin
    state_nxt     = state_r;
    spr_nxt       = spr_r;
    hold_nxt      = hold_r;
    out_valid_nxt = out_valid_r;
    out_dir_nxt   = out_dir_r;
    out_tap_nxt   = out_tap_r;
    out_drop_nxt  = out_drop_r;
    last_dir_nxt  = last_dir_r;
    last_time_nxt = last_time_r;
    clr_cnt_nxt   = clr_cnt_r;
    sensor_nxt    = sensor_r;
    addr_nxt      = addr_r;
    whole_nxt     = whole_r;
    micro_nxt     = micro_r;
    now_nxt       = now_r;
    mic_new_nxt   = mic_new_r;
    carry_nxt     = carry_r;
    deg_neg_nxt   = deg_neg_r;
    deg_abs_nxt   = deg_abs_r;
    steps_mag_nxt = steps_mag_r;
    steps_neg_nxt = steps_neg_r;

    ram_we    = 1'b0;
    ram_waddr = addr_r;
    ram_wdata = {rem_deg, mic_new_r};
    ram_re    = 1'b0;
    ram_raddr = erdl_pkg::STORE_AW'(32'(in_sensor) * erdl_pkg::NUM_LAYERS + 32'(in_layer));

    div_req.start    = 1'b0;
    div_req.iters    = erdl_pkg::DIV_CNT_W'(erdl_pkg::SPR_W);
    // 360 sits in the top bits, so 9 iterations yield 360 / spr
    div_req.dividend = {erdl_pkg::SPR_W'(erdl_pkg::DEGREES_PER_TURN),
                        (erdl_pkg::DIV_DVD_W - erdl_pkg::SPR_W)'(0)};
    div_req.divisor  = spr_eff;

    if (cfg_valid && cfg_ready) begin
      case (erdl_pkg::cfg_idx_t'(cfg_index))
        erdl_pkg::CFG_STEPS_PER_ROT: spr_nxt  = cfg_data[erdl_pkg::SPR_W-1:0];
        erdl_pkg::CFG_HOLD_TIME:     hold_nxt = cfg_data;
        default: ;
      endcase
    end

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
        ram_wdata = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == erdl_pkg::STORE_AW'(erdl_pkg::STORE_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          sensor_nxt = in_sensor;
          addr_nxt   = ram_raddr;
          whole_nxt  = in_whole;
          micro_nxt  = in_micro;
          now_nxt    = in_now;
          if (!idx_ok) begin
            steps_mag_nxt = '0;
            steps_neg_nxt = 1'b0;
            state_nxt     = S_LOCK;
          end else if (in_whole == '0) begin
            // raw step mode
            steps_mag_nxt = in_micro[20] ? (21'd0 - in_micro) : in_micro;
            steps_neg_nxt = in_micro[20];
            state_nxt     = S_LOCK;
          end else begin
            ram_re        = 1'b1;
            div_req.start = 1'b1;
            state_nxt     = S_CARRY;
          end
        end
      end

      S_CARRY: begin
        if (mic_sum >= MIC_TWO) begin
          carry_nxt   = 3'sd2;
          mic_new_nxt = 21'(mic_sum - MIC_TWO);
        end else if (mic_sum >= MIC_ONE) begin
          carry_nxt   = 3'sd1;
          mic_new_nxt = 21'(mic_sum - MIC_ONE);
        end else if (mic_sum <= MIC_NEG_TWO) begin
          carry_nxt   = -3'sd2;
          mic_new_nxt = 21'(mic_sum + MIC_TWO);
        end else if (mic_sum <= MIC_NEG_ONE) begin
          carry_nxt   = -3'sd1;
          mic_new_nxt = 21'(mic_sum + MIC_ONE);
        end else begin
          carry_nxt   = 3'sd0;
          mic_new_nxt = 21'(mic_sum);
        end
        state_nxt = S_SUM;
      end

      S_SUM: begin
        deg_neg_nxt = deg_sum[17];
        deg_abs_nxt = deg_mag[15:0];
        state_nxt   = S_DIV1;
      end

      S_DIV1: begin
        if (!div_rsp.busy) begin
          div_req.start    = 1'b1;
          div_req.iters    = erdl_pkg::DIV_CNT_W'(erdl_pkg::DIV_DVD_W);
          div_req.dividend = deg_abs_r;
          div_req.divisor  = div_rsp.quotient[erdl_pkg::DIV_DVS_W-1:0];
          state_nxt        = S_DIV2;
        end
      end

      S_DIV2: begin
        if (!div_rsp.busy) begin
          ram_we        = 1'b1;
          steps_mag_nxt = 21'(div_rsp.quotient);
          steps_neg_nxt = deg_neg_r;
          state_nxt     = S_LOCK;
        end
      end

      S_LOCK: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_dir_nxt   = erdl_pkg::DIR_NONE;
          out_tap_nxt   = '0;
          out_drop_nxt  = 1'b0;
          if (nonzero) begin
            last_time_nxt[sidx] = now_r;
            if (drop) begin
              out_drop_nxt = 1'b1;
            end else begin
              last_dir_nxt[sidx] = step_dir;
              out_dir_nxt        = step_dir;
              out_tap_nxt        = (steps_mag_r > 21'(erdl_pkg::TAP_MAX))
                                 ? 16'(erdl_pkg::TAP_MAX) : steps_mag_r[15:0];
            end
          end
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      spr_r       <= erdl_pkg::SPR_W'(20);
      hold_r      <= erdl_pkg::HOLD_W'(100);
      out_valid_r <= 1'b0;
      clr_cnt_r   <= '0;
      for (int i = 0; i < erdl_pkg::NUM_SENSORS; i++) begin
        last_dir_r[i]  <= erdl_pkg::DIR_NONE;
        last_time_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      spr_r       <= spr_nxt;
      hold_r      <= hold_nxt;
      out_valid_r <= out_valid_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      last_dir_r  <= last_dir_nxt;
      last_time_r <= last_time_nxt;
    end
    out_dir_r   <= out_dir_nxt;
    out_tap_r   <= out_tap_nxt;
    out_drop_r  <= out_drop_nxt;
    sensor_r    <= sensor_nxt;
    addr_r      <= addr_nxt;
    whole_r     <= whole_nxt;
    micro_r     <= micro_nxt;
    now_r       <= now_nxt;
    mic_new_r   <= mic_new_nxt;
    carry_r     <= carry_nxt;
    deg_neg_r   <= deg_neg_nxt;
    deg_abs_r   <= deg_abs_nxt;
    steps_mag_r <= steps_mag_nxt;
    steps_neg_r <= steps_neg_nxt;
  end

  erdl_ram #(
    .WIDTH (erdl_pkg::REM_W),
    .DEPTH (erdl_pkg::STORE_DEPTH)
  ) u_rem_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  erdl_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_drop_r, out_tap_r, out_dir_r};

endmodule
`default_nettype wire
